### sv/ternary_pair_packer_with_na_runs_core_assert.svh
// Assertion macros for the ternary pair packer core.
`ifndef TERNARY_PAIR_PACKER_WITH_NA_RUNS_CORE_ASSERT_SVH
`define TERNARY_PAIR_PACKER_WITH_NA_RUNS_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define TPP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define TPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TPP_ASSERT_ALWAYS(label, cond, msg)
`define TPP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### sv/tpp_pkg.sv
// Shared types and constants of the ternary pair packer.
`default_nettype none

package tpp_pkg;

    localparam logic [6:0] COUNT_CAP = 7'd126;
    localparam logic       PAIR_MARK = 1'b1;

    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_PTR_W;
    localparam int QUEUE_LVL_W = QUEUE_PTR_W + 1;

    typedef enum logic [1:0] {
        CLASS_NONE    = 2'd0,
        CLASS_DATA    = 2'd1,
        CLASS_MISSING = 2'd2
    } class_t;

    typedef struct packed {
        logic [7:0] pack_byte;
        logic [1:0] pair_slot;
        logic [6:0] missing_count;
        class_t     prev_class;
    } state_t;

    localparam state_t STATE_RESET = '{
        pack_byte:     8'd0,
        pair_slot:     2'd0,
        missing_count: 7'd0,
        prev_class:    CLASS_NONE
    };

    // Up to two code bytes per input beat, in order.
    typedef struct packed {
        logic [1:0] num;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } step_out_t;

    typedef struct packed {
        logic [QUEUE_LVL_W-1:0] level;
        logic                   room;
    } q_status_t;

endpackage

`default_nettype wire

### sv/tpp_step.sv
// Per-symbol next-state and code byte logic of the ternary pair packer.
`default_nettype none

module tpp_step
    import tpp_pkg::*;
(
    input  state_t     state_cur,
    input  logic [7:0] value,
    input  logic       end_of_stream,
    output state_t     state_nxt,
    output step_out_t  emit
);

    always_comb
    begin
        state_t     s;
        logic [1:0] num;
        logic [7:0] b0;
        logic [7:0] b1;

        s   = state_cur;
        num = 2'd0;
        b0  = 8'd0;
        b1  = 8'd0;

        if (value[7:1] == 7'd0)
        begin
            if (s.prev_class == CLASS_MISSING && s.missing_count != 7'd0)
            begin
                b0  = {1'b0, s.missing_count};
                num = 2'd1;
                s.missing_count = 7'd0;
            end
            case (s.pair_slot)
                2'd0:    s.pack_byte[7:6] = {PAIR_MARK, value[0]};
                2'd1:    s.pack_byte[5:4] = {PAIR_MARK, value[0]};
                2'd2:    s.pack_byte[3:2] = {PAIR_MARK, value[0]};
                default: s.pack_byte[1:0] = {PAIR_MARK, value[0]};
            endcase
            if (s.pair_slot == 2'd3)
            begin
                if (num == 2'd0)
                    b0 = s.pack_byte;
                else
                    b1 = s.pack_byte;
                num = num + 2'd1;
                s.pack_byte = 8'd0;
                s.pair_slot = 2'd0;
            end
            else
            begin
                s.pair_slot = s.pair_slot + 2'd1;
            end
            s.prev_class = CLASS_DATA;
        end
        else
        begin
            if (s.prev_class == CLASS_DATA && s.pack_byte != 8'd0)
            begin
                b0  = s.pack_byte;
                num = 2'd1;
                s.pack_byte = 8'd0;
                s.pair_slot = 2'd0;
            end
            s.missing_count = s.missing_count + 7'd1;
            if (s.missing_count >= COUNT_CAP)
            begin
                if (num == 2'd0)
                    b0 = {1'b0, s.missing_count};
                else
                    b1 = {1'b0, s.missing_count};
                num = num + 2'd1;
                s.missing_count = 7'd0;
            end
            s.prev_class = CLASS_MISSING;
        end

        if (end_of_stream)
        begin
            if (s.prev_class == CLASS_DATA && s.pack_byte != 8'd0)
            begin
                if (num == 2'd0)
                    b0 = s.pack_byte;
                else
                    b1 = s.pack_byte;
                num = num + 2'd1;
            end
            else if (s.prev_class == CLASS_MISSING && s.missing_count != 7'd0)
            begin
                if (num == 2'd0)
                    b0 = {1'b0, s.missing_count};
                else
                    b1 = {1'b0, s.missing_count};
                num = num + 2'd1;
            end
            s = STATE_RESET;
        end

        state_nxt  = s;
        emit.num   = num;
        emit.byte0 = b0;
        emit.byte1 = b1;
    end

endmodule

`default_nettype wire

### sv/tpp_outq.sv
// Result queue: takes up to two code bytes per cycle, hands out one per beat.
`default_nettype none

module tpp_outq
    import tpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  step_out_t  emit,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] code_byte,
    output logic       last_of_run,
    output q_status_t  status
);

    logic [8:0]             mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_LVL_W-1:0] level_reg;
    logic [QUEUE_LVL_W-1:0] level_next;
    logic [QUEUE_LVL_W-1:0] push_num;
    logic                   pop;

    assign pop      = result_valid && result_ready;
    assign push_num = push ? QUEUE_LVL_W'(emit.num) : '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push_num);
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        level_next  = level_reg + push_num - (pop ? QUEUE_LVL_W'(1) : '0);
    end

    always_ff @(posedge clk)
    begin
        if (push && emit.num != 2'd0)
        begin
            mem[wr_ptr_reg] <= {emit.byte0, emit.num == 2'd1};
        end
        if (push && emit.num == 2'd2)
        begin
            mem[wr_ptr_reg + QUEUE_PTR_W'(1)] <= {emit.byte1, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign result_valid = level_reg != '0;
    assign code_byte    = mem[rd_ptr_reg][8:1];
    assign last_of_run  = mem[rd_ptr_reg][0];
    assign status.level = level_reg;
    assign status.room  = level_reg <= QUEUE_LVL_W'(QUEUE_DEPTH - 2);

endmodule

`default_nettype wire

### sv/ternary_pair_packer_with_na_runs_core.sv
// Top level of the ternary pair packer with missing-value run counts.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------
//  item     | item_valid / item_ready     | value[7:0], end_of_stream
//  result   | result_valid / result_ready | code_byte[7:0], last_of_run
//
// One symbol per cycle while the queue has room: a beat is held in the
// input register, is folded into the packer state, and its 0..2 code bytes
// enter a 4-entry queue; the first one can leave the cycle after that.
// Results leave one per cycle while result_ready is high, so a symbol with
// two code bytes needs an extra output slot; the queue absorbs it.
// The input register holds while the queue has fewer than two free entries.
// Reset empties the queue and returns the packer state to idle.
`default_nettype none
`include "ternary_pair_packer_with_na_runs_core_assert.svh"

module ternary_pair_packer_with_na_runs_core
    import tpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] value,
    input  logic       end_of_stream,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] code_byte,
    output logic       last_of_run
);

    logic       in_valid_reg;
    logic [7:0] value_reg;
    logic       eos_reg;
    state_t     state_reg;
    state_t     state_next;
    step_out_t  emit;
    q_status_t  q_status;
    logic       process;

    assign process    = in_valid_reg && q_status.room;
    assign item_ready = !in_valid_reg || process;

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            value_reg <= value;
            eos_reg   <= end_of_stream;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= STATE_RESET;
        end
        else
        begin
            if (item_ready)
                in_valid_reg <= item_valid;
            if (process)
                state_reg <= state_next;
        end
    end

    tpp_step u_step (
        .state_cur     (state_reg),
        .value         (value_reg),
        .end_of_stream (eos_reg),
        .state_nxt     (state_next),
        .emit          (emit)
    );

    tpp_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (process),
        .emit         (emit),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .code_byte    (code_byte),
        .last_of_run  (last_of_run),
        .status       (q_status)
    );

    `TPP_ASSERT_ALWAYS(a_queue_bound, q_status.level <= QUEUE_LVL_W'(QUEUE_DEPTH), "queue overflow")
    `TPP_ASSERT_ALWAYS(a_count_cap, state_reg.missing_count < COUNT_CAP, "missing count at cap")
    `TPP_ASSERT_NEXT(a_eos_clears, process && eos_reg, state_reg == STATE_RESET, "state not cleared")
    `TPP_ASSERT_NEXT(a_data_class, process && !eos_reg && value_reg[7:1] == 7'd0, state_reg.prev_class == CLASS_DATA && state_reg.missing_count == 7'd0, "data symbol left count")

endmodule

`default_nettype wire
